[rtl/core/wrd_pkg.sv]
// ----------------------------------------------------------------------------
// wrd_pkg: shared types and constants of the wide restoring divider
// Field widths, item structs and sequencer states used by all divider files.
// ----------------------------------------------------------------------------
package wrd_pkg;

  // Fixed widths of the operand and result fields.
  localparam int LOW_W         = 64;
  localparam int HIGH_W        = 32;
  localparam int FIELD_W       = LOW_W + HIGH_W;
  localparam int DEF_OPERAND_W = 96;

  typedef struct packed {
    logic [LOW_W-1:0]  dividend_low;
    logic [HIGH_W-1:0] dividend_high;
    logic [LOW_W-1:0]  divisor_low;
    logic [HIGH_W-1:0] divisor_high;
  } wrd_in_t;

  typedef struct packed {
    logic [LOW_W-1:0]  quotient_low;
    logic [HIGH_W-1:0] quotient_high;
    logic [LOW_W-1:0]  remainder_low;
    logic [HIGH_W-1:0] remainder_high;
    logic              status;
  } wrd_out_t;

  // Status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } wrd_state_t;

endpackage

[rtl/core/wrd_step.sv]
// ----------------------------------------------------------------------------
// wrd_step: one restoring division step
// Shifts the next dividend bit into the partial remainder and subtracts the
// divisor when it fits, giving one quotient bit.
// ----------------------------------------------------------------------------
module wrd_step #(
  parameter int OPERAND_WIDTH = wrd_pkg::DEF_OPERAND_W
) (
  input  logic [OPERAND_WIDTH-1:0] rem,
  input  logic                     next_bit,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic [OPERAND_WIDTH-1:0] rem_nxt,
  output logic                     q_bit
);
  import wrd_pkg::*;

  logic [OPERAND_WIDTH:0]   partial;
  logic [OPERAND_WIDTH+1:0] diff;

  // The partial remainder stays below the divisor, so the shifted value is
  // below twice the divisor and the difference always fits back in the width.
  assign partial = {rem, next_bit};
  assign diff    = {1'b0, partial} - {2'b00, divisor};
  assign q_bit   = ~diff[OPERAND_WIDTH+1];
  assign rem_nxt = q_bit ? diff[OPERAND_WIDTH-1:0] : partial[OPERAND_WIDTH-1:0];

endmodule

[rtl/core/wide_restoring_divider_top.sv]
// ----------------------------------------------------------------------------
// wide_restoring_divider_top: unsigned restoring divider, wide operands
// Divides an unsigned dividend by an unsigned divisor and returns quotient,
// remainder and a divide-by-zero status, one quotient bit per clock.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   dividend and divisor (wrd_in_t)
//   out_     output     out_valid / out_stall quotient, remainder, status
//
// An item is handled in order: the operands are loaded, the quotient bits are
// formed one after another through the shared subtract-and-compare step, and
// the result moves to the output register once that register is free. A zero
// divisor skips the bit loop.
// Reset is synchronous and active low; it clears the sequencer and the
// output valid flag. The block takes one item at a time. A finished result
// sits in the output register while a new item is accepted and worked on;
// if the output is still stalled when that next result is ready, the
// sequencer waits in its done state.
//
module wide_restoring_divider_top #(
  parameter int OPERAND_WIDTH = wrd_pkg::DEF_OPERAND_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  wrd_pkg::wrd_in_t in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output wrd_pkg::wrd_out_t out_item
);
  import wrd_pkg::*;

  // Working width covering both the operand width and the field width, so
  // operands can be zero-extended or cut without a special case.
  localparam int EXT_W = (OPERAND_WIDTH > FIELD_W) ? OPERAND_WIDTH : FIELD_W;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam logic [CNT_W-1:0] CNT_START = CNT_W'(OPERAND_WIDTH - 1);

  wrd_state_t state_r, state_nxt;

  logic [OPERAND_WIDTH-1:0] rem_r;
  logic [OPERAND_WIDTH-1:0] aq_r;
  logic [OPERAND_WIDTH-1:0] div_r;
  logic                     zero_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     out_valid_r, out_valid_nxt;
  wrd_out_t                 out_item_r;

  logic [FIELD_W-1:0]       a_full, b_full;
  logic [EXT_W-1:0]         a_ext, b_ext, q_ext, r_ext;
  logic [OPERAND_WIDTH-1:0] a_w, b_w;
  logic                     b_zero;
  logic [OPERAND_WIDTH-1:0] rem_step;
  logic                     q_bit;

  logic load_in, step_en, load_out, out_free;

  // Operands are cut to the operand width (or zero-extended above the field
  // width) before division.
  assign a_full = {in_item.dividend_high, in_item.dividend_low};
  assign b_full = {in_item.divisor_high, in_item.divisor_low};
  assign a_ext  = EXT_W'(a_full);
  assign b_ext  = EXT_W'(b_full);
  assign a_w    = a_ext[OPERAND_WIDTH-1:0];
  assign b_w    = b_ext[OPERAND_WIDTH-1:0];
  assign b_zero = (b_w == '0);

  // The shared step unit. The dividend shifts out of the top of aq_r while
  // the quotient bits shift in at the bottom.
  wrd_step #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_step (
    .rem      (rem_r),
    .next_bit (aq_r[OPERAND_WIDTH-1]),
    .divisor  (div_r),
    .rem_nxt  (rem_step),
    .q_bit    (q_bit)
  );

  // The output register is free when empty or when its item leaves now.
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    load_in   = 1'b0;
    step_en   = 1'b0;
    load_out  = 1'b0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          load_in   = 1'b1;
          // A zero divisor has nothing to iterate over.
          state_nxt = b_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        step_en = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      div_r  <= b_w;
      aq_r   <= b_zero ? '0 : a_w;
      rem_r  <= '0;
      zero_r <= b_zero;
      cnt_r  <= CNT_START;
    end else if (step_en) begin
      rem_r <= rem_step;
      aq_r  <= {aq_r[OPERAND_WIDTH-2:0], q_bit};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign q_ext = EXT_W'(aq_r);
  assign r_ext = EXT_W'(rem_r);

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item_r.quotient_low   <= q_ext[LOW_W-1:0];
      out_item_r.quotient_high  <= q_ext[FIELD_W-1:LOW_W];
      out_item_r.remainder_low  <= r_ext[LOW_W-1:0];
      out_item_r.remainder_high <= r_ext[FIELD_W-1:LOW_W];
      out_item_r.status         <= zero_r ? STATUS_DIV_ZERO : STATUS_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/wrd_checker.sv]
// ----------------------------------------------------------------------------
// wrd_checker: port-level checks for the wide restoring divider
// Watches the top level's channels and flags illegal behavior over time.
// ----------------------------------------------------------------------------
module wrd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input wrd_pkg::wrd_out_t out_item
);
  import wrd_pkg::*;

  // A stalled result item holds its place and its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed or vanished");

  // Division by zero reports zero quotient and remainder.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == STATUS_DIV_ZERO |->
      out_item.quotient_low == '0 && out_item.quotient_high == '0 &&
      out_item.remainder_low == '0 && out_item.remainder_high == '0)
    else $error("divide by zero with nonzero result");

  // The divider takes one item at a time: after an accept it is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A new result cannot appear in the cycle after an input item was taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind wide_restoring_divider_top wrd_checker u_wrd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the wide restoring divider
// Drives directed corner divisions and then about 480 random divisions of
// shaped operand lengths through the valid/stall input channel. Every result
// taken from the output channel is compared field by field with a quotient,
// remainder and status worked out in the testbench. Both sides idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wrd_pkg::*;

  // The watchdog trips after this many cycles with no item moving on either side.
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 700;
  localparam int RANDOM_ITEMS    = 480;
  localparam int DRAIN_CYCLES    = DEF_OPERAND_W + 12;

  localparam logic [FIELD_W-1:0] OPERAND_MAX = '1;
  localparam logic [FIELD_W-1:0] OPERAND_ONE = FIELD_W'(1);
  localparam logic [FIELD_W-1:0] BIT_95      = OPERAND_ONE << (FIELD_W - 1);
  localparam logic [FIELD_W-1:0] BIT_64      = OPERAND_ONE << LOW_W;

  // One directed case. When the answer can be read off at a glance it is
  // typed in; otherwise the divide function below supplies it.
  typedef struct {
    wrd_in_t  operands;
    bit       answer_given;
    wrd_out_t answer;
  } division_case_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  wrd_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  wrd_out_t out_item;

  // Results still owed by the divider, oldest first.
  wrd_out_t       pending_quotients[$];
  division_case_t corner_divisions[$];
  int             items_taken;
  int             error_count;
  int             quiet_cycles;

  wide_restoring_divider_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic wrd_in_t pack_operands(input logic [FIELD_W-1:0] dividend,
                                            input logic [FIELD_W-1:0] divisor);
    wrd_in_t item;
    item.dividend_low  = dividend[LOW_W-1:0];
    item.dividend_high = dividend[FIELD_W-1:LOW_W];
    item.divisor_low   = divisor[LOW_W-1:0];
    item.divisor_high  = divisor[FIELD_W-1:LOW_W];
    return item;
  endfunction

  function automatic wrd_out_t pack_result(input logic [FIELD_W-1:0] quotient,
                                           input logic [FIELD_W-1:0] remainder,
                                           input logic               status);
    wrd_out_t res;
    res.quotient_low   = quotient[LOW_W-1:0];
    res.quotient_high  = quotient[FIELD_W-1:LOW_W];
    res.remainder_low  = remainder[LOW_W-1:0];
    res.remainder_high = remainder[FIELD_W-1:LOW_W];
    res.status         = status;
    return res;
  endfunction

  // Expected answer of one division. The operands fill the 96-bit width
  // exactly, so no truncation applies, and the restoring loop of the divider
  // must land on the plain floor quotient and remainder. A zero divisor
  // flags the error and leaves quotient and remainder at zero.
  function automatic wrd_out_t divide_operands(input wrd_in_t item);
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    dividend = {item.dividend_high, item.dividend_low};
    divisor  = {item.divisor_high, item.divisor_low};
    if (divisor == '0) begin
      return pack_result('0, '0, STATUS_DIV_ZERO);
    end
    return pack_result(dividend / divisor, dividend % divisor, STATUS_OK);
  endfunction

  function automatic division_case_t corner(input logic [FIELD_W-1:0] dividend,
                                            input logic [FIELD_W-1:0] divisor,
                                            input bit                 given,
                                            input logic [FIELD_W-1:0] quotient,
                                            input logic [FIELD_W-1:0] remainder,
                                            input logic               status);
    division_case_t c;
    c.operands     = pack_operands(dividend, divisor);
    c.answer_given = given;
    c.answer       = pack_result(quotient, remainder, status);
    return c;
  endfunction

  // Random operand whose value is limited to the given number of bits; half
  // of the time the top bit of that length is forced so the length is exact.
  function automatic logic [FIELD_W-1:0] random_operand(input int unsigned bits);
    logic [FIELD_W-1:0] v;
    v = {$urandom(), $urandom(), $urandom()};
    if (bits < FIELD_W) begin
      v &= (OPERAND_ONE << bits) - OPERAND_ONE;
    end
    if (bits > 0 && $urandom_range(0, 1) == 1) begin
      v[bits-1] = 1'b1;
    end
    return v;
  endfunction

  // Sender gap: mostly back to back, some short pauses, a few long ones so
  // that the next item shows up at every point of the running division.
  function automatic int sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 40);
    end
    return $urandom_range(60, 200);
  endfunction

  // Offers one item and returns at the edge where the divider takes it. The
  // expected answer is queued at that same edge. valid is lowered only when
  // a gap follows, so it never gets two assignments in one step.
  task automatic offer_division(input wrd_in_t item, input wrd_out_t answer);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    pending_quotients.push_back(answer);
    items_taken++;
  endtask

  // Stimulus: reset, the directed corner divisions, then random divisions.
  initial begin
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    wrd_in_t            item;
    int unsigned        pick;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;

    // Zero divisor, with both a zero and a full dividend: error status and
    // all-zero quotient and remainder.
    corner_divisions.push_back(corner('0, '0, 1'b1, '0, '0, STATUS_DIV_ZERO));
    corner_divisions.push_back(corner(OPERAND_MAX, '0, 1'b1, '0, '0, STATUS_DIV_ZERO));
    // Zero dividend gives a plain zero answer.
    corner_divisions.push_back(corner('0, OPERAND_MAX, 1'b1, '0, '0, STATUS_OK));
    corner_divisions.push_back(corner('0, OPERAND_ONE, 1'b1, '0, '0, STATUS_OK));
    // Divisor of one passes the dividend through.
    corner_divisions.push_back(corner(OPERAND_MAX, OPERAND_ONE, 1'b1, OPERAND_MAX, '0,
                                      STATUS_OK));
    corner_divisions.push_back(corner(BIT_95, OPERAND_ONE, 1'b1, BIT_95, '0, STATUS_OK));
    // Extremes of both operands.
    corner_divisions.push_back(corner(OPERAND_MAX, OPERAND_MAX, 1'b1, OPERAND_ONE, '0,
                                      STATUS_OK));
    corner_divisions.push_back(corner(OPERAND_MAX, FIELD_W'(2), 1'b1, OPERAND_MAX >> 1,
                                      OPERAND_ONE, STATUS_OK));
    corner_divisions.push_back(corner(OPERAND_MAX, FIELD_W'(3), 1'b1,
                                      96'h5555_5555_5555_5555_5555_5555, '0, STATUS_OK));
    corner_divisions.push_back(corner(OPERAND_MAX, BIT_64, 1'b1, FIELD_W'(32'hFFFF_FFFF),
                                      FIELD_W'(64'hFFFF_FFFF_FFFF_FFFF), STATUS_OK));
    corner_divisions.push_back(corner(BIT_95, BIT_95 - OPERAND_ONE, 1'b1, OPERAND_ONE,
                                      OPERAND_ONE, STATUS_OK));
    // Dividend smaller than the divisor: zero quotient, the dividend remains.
    corner_divisions.push_back(corner(OPERAND_ONE, OPERAND_MAX, 1'b1, '0, OPERAND_ONE,
                                      STATUS_OK));
    corner_divisions.push_back(corner(OPERAND_MAX - OPERAND_ONE, OPERAND_MAX, 1'b1, '0,
                                      OPERAND_MAX - OPERAND_ONE, STATUS_OK));
    corner_divisions.push_back(corner(FIELD_W'(7), FIELD_W'(12345), 1'b1, '0, FIELD_W'(7),
                                      STATUS_OK));
    corner_divisions.push_back(corner(FIELD_W'(12345), FIELD_W'(7), 1'b1, FIELD_W'(1763),
                                      FIELD_W'(4), STATUS_OK));
    corner_divisions.push_back(corner(96'h0123_4567_89AB_CDEF_0F1E_2D3C,
                                      96'h0123_4567_89AB_CDEF_0F1E_2D3C, 1'b1,
                                      OPERAND_ONE, '0, STATUS_OK));
    // Mixed patterns across the low/high field boundary.
    corner_divisions.push_back(corner(96'hA5A5_A5A5_A5A5_A5A5_A5A5_A5A5,
                                      96'h0000_005A_5A5A_5A5A_5A5A_5A5A, 1'b0, '0, '0, '0));
    corner_divisions.push_back(corner(96'hFFFF_FFFF_0000_0000_0000_0000,
                                      96'h0000_0001_0000_0000_0000_0001, 1'b0, '0, '0, '0));
    corner_divisions.push_back(corner(96'hFEDC_BA98_7654_3210_0123_4567,
                                      96'hFFFF_FFFF_0000_0000_0000_0000, 1'b0, '0, '0, '0));
    corner_divisions.push_back(corner(96'h0000_0000_FFFF_FFFF_FFFF_FFFF,
                                      96'h0000_0000_8000_0000_0000_0001, 1'b0, '0, '0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_divisions[i]) begin
      offer_division(corner_divisions[i].operands,
                     corner_divisions[i].answer_given ? corner_divisions[i].answer :
                     divide_operands(corner_divisions[i].operands));
    end

    // Random divisions. Operand lengths are drawn independently so that the
    // quotient length, and with it the work done per bit, spans its range.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick     = $urandom_range(0, 99);
      dividend = random_operand($urandom_range(1, FIELD_W));
      if (pick < 5) begin
        divisor = '0;
      end else if (pick < 12) begin
        divisor = FIELD_W'($urandom_range(1, 3));
      end else if (pick < 17) begin
        divisor = dividend + FIELD_W'($urandom_range(0, 1));
      end else begin
        divisor = random_operand($urandom_range(1, FIELD_W));
      end
      if (pick >= 96) begin
        dividend = '0;
      end
      item = pack_operands(dividend, divisor);
      offer_division(item, divide_operands(item));
    end
    in_valid <= 1'b0;

    // Drain: the watchdog ends the run if results stop coming.
    while (pending_quotients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side. Long open windows alternate with short and long stalls.
  // Once enough items have gone in, the receiver holds off for a long
  // stretch while the sender keeps offering, so that the output register
  // stays full, the next division finishes behind it and the input stalls.
  initial begin
    int          span;
    int unsigned pick;
    bit          held_off;

    out_stall = 1'b0;
    held_off  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && items_taken >= 60) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        span = HOLD_OFF_CYCLES;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 300);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(20, 150);
        end
      end
      repeat (span) @(posedge clk);
    end
  end

  // Result checker: every result taken is compared with the oldest answer
  // still owed.
  always @(posedge clk) begin
    wrd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_quotients.size() == 0) begin
        $error("result with no division outstanding: %h", out_item);
        error_count++;
      end else begin
        want = pending_quotients.pop_front();
        if (out_item.quotient_low !== want.quotient_low) begin
          $error("quotient_low: expected %h, got %h",
                 want.quotient_low, out_item.quotient_low);
          error_count++;
        end
        if (out_item.quotient_high !== want.quotient_high) begin
          $error("quotient_high: expected %h, got %h",
                 want.quotient_high, out_item.quotient_high);
          error_count++;
        end
        if (out_item.remainder_low !== want.remainder_low) begin
          $error("remainder_low: expected %h, got %h",
                 want.remainder_low, out_item.remainder_low);
          error_count++;
        end
        if (out_item.remainder_high !== want.remainder_high) begin
          $error("remainder_high: expected %h, got %h",
                 want.remainder_high, out_item.remainder_high);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_item.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_quotients.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/core/wrd_pkg.sv
rtl/core/wrd_step.sv
rtl/core/wide_restoring_divider_top.sv
rtl/core/wrd_checker.sv
test/tb_top.sv
